>>> rtl/fr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fr_pkg
// Shared constants and the per-stage item record of the refraction pipeline.
// ----------------------------------------------------------------------------
package fr_pkg;

  localparam int VEC_FRAC_BITS = 14;
  // rounding shift from the raw dot product down to Q.16
  localparam int COS_SHIFT     = 2 * VEC_FRAC_BITS - 16;
  // width of the rounded numerator in the component divide
  localparam int QNUM_W        = 24 + VEC_FRAC_BITS + 1;

  localparam logic [15:0] INDEX_RESET = 16'd16384;
  localparam logic [15:0] REFL_ONE    = 16'hFFFF;
  localparam logic [14:0] COMP_MAX    = 15'h7FFF;

  typedef enum logic {
    REG_TRANSMIT = 1'b0,
    REG_INCIDENT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [2:0][15:0]       v;
    logic [2:0][15:0]       n;
    logic [2:0][31:0]       pv;
    logic [17:0]            c;
    logic [32:0]            cc;
    logic [31:0]            nisq;
    logic [31:0]            ntsq;
    logic [64:0]            knum;
    logic [64:0]            krem;
    logic [33:0]            kq;
    logic                   kovf;
    logic [31:0]            erem;
    logic [31:0]            eta;
    logic                   tir;
    logic [32:0]            sx;
    logic [33:0]            sres;
    logic [16:0]            ct;
    logic [50:0]            etac;
    logic [34:0]            ntc;
    logic [34:0]            nic;
    logic [32:0]            nict;
    logic [32:0]            ntct;
    logic [35:0]            a16;
    logic [2:0][51:0]       an;
    logic [2:0][49:0]       ev;
    logic [2:0]             rneg;
    logic [2:0][52:0]       m;
    logic                   mz;
    logic [1:0][35:0]       fnum;
    logic [1:0][35:0]       fden;
    logic [1:0]             fzero;
    logic [1:0]             fovf;
    logic [1:0][60:0]       frem;
    logic [1:0][25:0]       fq;
    logic [2:0][23:0]       mt;
    logic [2:0][47:0]       msq;
    logic [49:0]            lx;
    logic [50:0]            lres;
    logic [2:0][QNUM_W-1:0] qrem;
    logic [2:0][14:0]       qq;
    logic [2:0]             qovf;
    logic [1:0][51:0]       rsq;
    logic [2:0][15:0]       refr;
    logic [15:0]            refl;
  } item_t;

endpackage

>>> rtl/fr_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fr_in_if
// Request channel: incident direction and surface normal.
// ----------------------------------------------------------------------------
interface fr_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] view_x;
  logic [15:0] view_y;
  logic [15:0] view_z;
  logic [15:0] normal_x;
  logic [15:0] normal_y;
  logic [15:0] normal_z;

  modport source (output valid, view_x, view_y, view_z, normal_x, normal_y, normal_z,
                  input ready);
  modport sink (input valid, view_x, view_y, view_z, normal_x, normal_y, normal_z,
                output ready);
endinterface

>>> rtl/fr_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fr_out_if
// Result channel: reflectance, refracted direction and total reflection flag.
// ----------------------------------------------------------------------------
interface fr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] reflectance;
  logic [15:0] refract_x;
  logic [15:0] refract_y;
  logic [15:0] refract_z;
  logic        total_reflection;

  modport source (output valid, reflectance, refract_x, refract_y, refract_z,
                  total_reflection, input ready);
  modport sink (input valid, reflectance, refract_x, refract_y, refract_z,
                total_reflection, output ready);
endinterface

>>> rtl/fresnel_refraction.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fresnel_refraction
// Snell refraction vector and unpolarised Fresnel reflectance, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_ch_i (view and normal, signed Q1.14) and results leave
//   on out_ch_o (reflectance Q0.16, unit refracted direction Q1.14, flag).
//   Both channels move an item when valid and ready are high at a clock edge.
//   The two refractive indices sit in APB registers at 0x0 (transmit) and
//   0x4 (incident); write them only while the pipeline is empty.
//   Throughput: one request per cycle while out_ch_o is not stalled. The
//   pipeline depth is set mostly by the bit-serial divide and square root
//   chains, one quotient or root bit per stage. When the receiver stalls
//   with a result waiting on out_ch_o, the whole pipeline holds and
//   in_ch_i.ready drops in the same cycle; nothing is lost or repeated.
//   Reset empties the pipeline and sets both indices to 1.0.
// ----------------------------------------------------------------------------
module fresnel_refraction (
  input  logic        clk_i,
  input  logic        rst_ni,
  fr_in_if.sink       in_ch_i,
  fr_out_if.source    out_ch_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fr_pkg::*;

  localparam int S_DOT  = 0;
  localparam int S_COS  = S_DOT + 1;
  localparam int S_SQ   = S_COS + 1;
  localparam int S_NUM  = S_SQ + 1;
  localparam int S_KOVF = S_NUM + 1;
  localparam int S_KDIV = S_KOVF + 1;
  localparam int S_TIR  = S_KDIV + 34;
  localparam int S_CT   = S_TIR + 1;
  localparam int S_M1   = S_CT + 17;
  localparam int S_M2   = S_M1 + 1;
  localparam int S_M3   = S_M2 + 1;
  localparam int S_M4   = S_M3 + 1;
  localparam int S_R    = S_M4 + 1;
  localparam int S_NRM  = S_R + 1;
  localparam int S_FOV  = S_R + 1;
  localparam int S_FDIV = S_FOV + 1;
  localparam int S_MT   = S_NRM + 6;
  localparam int S_SUM  = S_MT + 1;
  localparam int S_LEN  = S_SUM + 1;
  localparam int S_QOV  = S_LEN + 25;
  localparam int S_QDIV = S_QOV + 1;
  localparam int S_OUT  = S_QDIV + 15;
  localparam int S_FIN  = S_OUT + 1;
  localparam int N_FN   = S_FIN + 1;
  localparam int N_REG  = N_FN + 1;

  logic [15:0] tidx_q;
  logic [15:0] iidx_q;
  logic        wr_en;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tidx_q <= INDEX_RESET;
      iidx_q <= INDEX_RESET;
    end else if (wr_en) begin
      case (reg_idx_e'(paddr[2]))
        REG_TRANSMIT: tidx_q <= pwdata[15:0];
        REG_INCIDENT: iidx_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[2]))
      REG_TRANSMIT: prdata = {16'b0, tidx_q};
      REG_INCIDENT: prdata = {16'b0, iidx_q};
      default:      prdata = 32'b0;
    endcase
  end

  // --------------------------------------------------------------------------
  // One pipeline step; s selects which part of the work the stage performs
  // --------------------------------------------------------------------------
  function automatic item_t stage_fn(input int s, input item_t x,
                                     input logic [15:0] ni, input logic [15:0] nt);
    item_t             y;
    logic [15:0]       ntd;
    logic signed [33:0] dot;
    logic [33:0]       dmag;
    logic [33:0]       cmag;
    logic [32:0]       s2;
    logic [65:0]       kdv;
    logic [47:0]       edv;
    logic [33:0]       sbit;
    logic [33:0]       st;
    logic signed [51:0] at;
    logic [51:0]       amag;
    logic signed [52:0] r;
    logic signed [35:0] fn;
    logic signed [35:0] fd;
    logic [62:0]       fdv;
    logic              topz;
    logic [23:0]       mtl;
    logic [50:0]       lbit;
    logic [50:0]       lt;
    logic [QNUM_W:0]   qdv;
    logic [QNUM_W-1:0] qn;
    logic [14:0]       comp;
    logic [25:0]       rr;
    logic [52:0]       rsum;
    logic [19:0]       rf;
    int                i;
    int                j;
    int                b;

    y   = x;
    ntd = (nt == 16'd0) ? 16'd1 : nt;

    if (s == S_DOT) begin
      for (i = 0; i < 3; i++) y.pv[i] = $signed(x.v[i]) * $signed(x.n[i]);
    end

    if (s == S_COS) begin
      dot  = $signed(x.pv[0]) + $signed(x.pv[1]) + $signed(x.pv[2]);
      dmag = dot[33] ? 34'(-dot) : 34'(dot);
      if (COS_SHIFT > 0) cmag = (dmag + (34'd1 << (COS_SHIFT - 1))) >> COS_SHIFT;
      else cmag = dmag;
      if (cmag > 34'd65536) cmag = 34'd65536;
      // cos_i is the negated dot product
      y.c = (dot > 0) ? 18'(-cmag[17:0]) : cmag[17:0];
    end

    if (s == S_SQ) begin
      y.cc   = $signed(x.c) * $signed(x.c);
      y.nisq = {16'b0, ni} * {16'b0, ni};
      y.ntsq = {16'b0, ntd} * {16'b0, ntd};
    end

    if (s == S_NUM) begin
      s2     = 33'h1_0000_0000 - x.cc;
      y.knum = 65'(x.nisq) * 65'(s2);
      y.erem = {ni, 16'b0};
      y.eta  = 32'b0;
      y.kq   = 34'b0;
    end

    if (s == S_KOVF) begin
      kdv    = 66'(x.ntsq) << 34;
      y.kovf = 66'(x.knum) >= kdv;
      y.krem = x.knum;
    end

    if (s >= S_KDIV && s < S_TIR) begin
      j   = s - S_KDIV;
      b   = 33 - j;
      kdv = 66'(x.ntsq) << b;
      if (66'(x.krem) >= kdv) begin
        y.krem  = 65'(66'(x.krem) - kdv);
        y.kq[b] = 1'b1;
      end
      // eta shares the sweep once the bit falls inside its quotient
      if (b <= 31) begin
        edv = 48'(ntd) << b;
        if (48'(x.erem) >= edv) begin
          y.erem   = 32'(48'(x.erem) - edv);
          y.eta[b] = 1'b1;
        end
      end
    end

    if (s == S_TIR) begin
      y.tir  = x.kovf || (x.kq > 34'h1_0000_0000);
      y.sx   = y.tir ? 33'b0 : 33'h1_0000_0000 - x.kq[32:0];
      y.sres = 34'b0;
    end

    if (s >= S_CT && s < S_M1) begin
      j    = s - S_CT;
      sbit = 34'd1 << (32 - 2 * j);
      st   = x.sres + sbit;
      if (34'(x.sx) >= st) begin
        y.sx   = 33'(34'(x.sx) - st);
        y.sres = (x.sres >> 1) + sbit;
      end else begin
        y.sres = x.sres >> 1;
      end
    end

    if (s == S_M1) begin
      y.ct   = x.sres[16:0];
      y.etac = $signed({1'b0, x.eta}) * $signed(x.c);
      y.ntc  = $signed({1'b0, nt}) * $signed(x.c);
    end

    if (s == S_M2) begin
      at    = $signed(x.etac) - $signed({1'b0, x.ct, 16'b0});
      amag  = at[51] ? 52'(-at) : 52'(at);
      amag  = (amag + 52'd32768) >> 16;
      y.a16 = at[51] ? 36'(-amag[35:0]) : amag[35:0];
      y.nic = $signed({1'b0, ni}) * $signed(x.c);
    end

    if (s == S_M3) begin
      for (i = 0; i < 3; i++) y.an[i] = $signed(x.a16) * $signed(x.n[i]);
      y.nict = {16'b0, ni} * {16'b0, x.ct};
    end

    if (s == S_M4) begin
      for (i = 0; i < 3; i++) y.ev[i] = $signed({1'b0, x.eta}) * $signed(x.v[i]);
      y.ntct = {16'b0, nt} * {16'b0, x.ct};
    end

    if (s == S_R) begin
      for (i = 0; i < 3; i++) begin
        r         = $signed(x.an[i]) + $signed(x.ev[i]);
        y.rneg[i] = r[52];
        y.m[i]    = r[52] ? 53'(-r) : 53'(r);
      end
      y.mz = (y.m[0] == 53'b0) && (y.m[1] == 53'b0) && (y.m[2] == 53'b0);
      fn = $signed(x.ntc) - $signed({1'b0, x.nict});
      fd = $signed(x.ntc) + $signed({1'b0, x.nict});
      y.fnum[0]  = fn[35] ? 36'(-fn) : 36'(fn);
      y.fden[0]  = fd[35] ? 36'(-fd) : 36'(fd);
      y.fzero[0] = (fd == 36'sd0);
      fn = $signed(x.nic) - $signed({1'b0, x.ntct});
      fd = $signed(x.nic) + $signed({1'b0, x.ntct});
      y.fnum[1]  = fn[35] ? 36'(-fn) : 36'(fn);
      y.fden[1]  = fd[35] ? 36'(-fd) : 36'(fd);
      y.fzero[1] = (fd == 36'sd0);
    end

    if (s == S_FOV) begin
      for (i = 0; i < 2; i++) begin
        fdv       = 63'(x.fden[i]) << 26;
        y.fovf[i] = (63'(x.fnum[i]) << 24) >= fdv;
        y.frem[i] = 61'(x.fnum[i]) << 24;
        y.fq[i]   = 26'b0;
      end
    end

    if (s >= S_FDIV && s < S_FDIV + 26) begin
      j = s - S_FDIV;
      b = 25 - j;
      for (i = 0; i < 2; i++) begin
        fdv = 63'(x.fden[i]) << b;
        if (63'(x.frem[i]) >= fdv) begin
          y.frem[i]    = 61'(63'(x.frem[i]) - fdv);
          y.fq[i][b]   = 1'b1;
        end
      end
    end

    // shift all three magnitudes together until the largest tops the word
    if (s >= S_NRM && s < S_MT) begin
      j    = s - S_NRM;
      b    = 32 >> j;
      topz = ((x.m[0] | x.m[1] | x.m[2]) >> (53 - b)) == 53'b0;
      if (topz) begin
        for (i = 0; i < 3; i++) y.m[i] = x.m[i] << b;
      end
    end

    if (s == S_MT) begin
      for (i = 0; i < 3; i++) begin
        mtl      = x.m[i][52:29];
        y.mt[i]  = mtl;
        y.msq[i] = {24'b0, mtl} * {24'b0, mtl};
      end
    end

    if (s == S_SUM) begin
      y.lx   = 50'(x.msq[0]) + 50'(x.msq[1]) + 50'(x.msq[2]);
      y.lres = 51'b0;
    end

    if (s >= S_LEN && s < S_QOV) begin
      j    = s - S_LEN;
      lbit = 51'd1 << (48 - 2 * j);
      lt   = x.lres + lbit;
      if (51'(x.lx) >= lt) begin
        y.lx   = 50'(51'(x.lx) - lt);
        y.lres = (x.lres >> 1) + lbit;
      end else begin
        y.lres = x.lres >> 1;
      end
    end

    if (s == S_QOV) begin
      for (i = 0; i < 3; i++) begin
        qn        = (QNUM_W'(x.mt[i]) << VEC_FRAC_BITS) + QNUM_W'(x.lres[24:1]);
        qdv       = (QNUM_W+1)'(x.lres[24:0]) << 15;
        y.qovf[i] = (QNUM_W+1)'(qn) >= qdv;
        y.qrem[i] = qn;
        y.qq[i]   = 15'b0;
      end
    end

    if (s >= S_QDIV && s < S_OUT) begin
      j = s - S_QDIV;
      b = 14 - j;
      for (i = 0; i < 3; i++) begin
        qdv = (QNUM_W+1)'(x.lres[24:0]) << b;
        if ((QNUM_W+1)'(x.qrem[i]) >= qdv) begin
          y.qrem[i]  = QNUM_W'((QNUM_W+1)'(x.qrem[i]) - qdv);
          y.qq[i][b] = 1'b1;
        end
      end
    end

    if (s == S_OUT) begin
      for (i = 0; i < 3; i++) begin
        comp      = x.qovf[i] ? COMP_MAX : x.qq[i];
        y.refr[i] = x.rneg[i] ? 16'(-{1'b0, comp}) : {1'b0, comp};
        if (x.mz || x.tir) y.refr[i] = 16'b0;
      end
      for (i = 0; i < 2; i++) begin
        // a zero denominator counts as a ratio of one; limit at two
        if (x.fzero[i]) rr = 26'd1 << 24;
        else if (x.fovf[i] || (x.fq[i] > (26'd1 << 25))) rr = 26'd1 << 25;
        else rr = x.fq[i];
        y.rsq[i] = {26'b0, rr} * {26'b0, rr};
      end
    end

    if (s == S_FIN) begin
      rsum   = 53'(x.rsq[0]) + 53'(x.rsq[1]) + (53'd1 << 32);
      rf     = rsum[52:33];
      y.refl = (rf > 20'(REFL_ONE) || x.tir) ? REFL_ONE : rf[15:0];
    end

    return y;
  endfunction

  // --------------------------------------------------------------------------
  // Pipeline: every stage advances together unless the output is held
  // --------------------------------------------------------------------------
  item_t            pipe_q [N_REG];
  item_t            pipe_d [N_FN];
  item_t            in_item;
  logic [N_REG-1:0] vld_q;
  logic             adv;

  assign adv              = !vld_q[N_REG-1] || out_ch_o.ready;
  assign in_ch_i.ready    = adv;

  always_comb begin
    in_item      = '0;
    in_item.v[0] = in_ch_i.view_x;
    in_item.v[1] = in_ch_i.view_y;
    in_item.v[2] = in_ch_i.view_z;
    in_item.n[0] = in_ch_i.normal_x;
    in_item.n[1] = in_ch_i.normal_y;
    in_item.n[2] = in_ch_i.normal_z;
  end

  for (genvar g = 0; g < N_FN; g++) begin : g_stage
    always_comb begin
      pipe_d[g] = stage_fn(g, pipe_q[g], iidx_q, tidx_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[N_REG-2:0], in_ch_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pipe_q[0] <= in_item;
      for (int k = 0; k < N_FN; k++) pipe_q[k+1] <= pipe_d[k];
    end
  end

  assign out_ch_o.valid            = vld_q[N_REG-1];
  assign out_ch_o.reflectance      = pipe_q[N_REG-1].refl;
  assign out_ch_o.refract_x        = pipe_q[N_REG-1].refr[0];
  assign out_ch_o.refract_y        = pipe_q[N_REG-1].refr[1];
  assign out_ch_o.refract_z        = pipe_q[N_REG-1].refr[2];
  assign out_ch_o.total_reflection = pipe_q[N_REG-1].tir;

endmodule
